>>> rtl/core/multilevel_feedback_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfs assertion failed");

// The condition must never be true.
`define MFS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mfs assertion failed");

`endif

>>> rtl/core/mfs_pkg.sv
package mfs_pkg;

	localparam int NUM_LEVELS = 10;
	localparam int LVL_W = 4;
	localparam int ID_W = 4;
	localparam int CMD_W = 3;
	localparam int CLS_W = 3;
	localparam int ERR_W = 2;

	localparam logic [CMD_W-1:0] CMD_NEW = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_IOREQ = 3'd2;
	localparam logic [CMD_W-1:0] CMD_IODONE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TERM = 3'd4;

	localparam logic [CLS_W-1:0] CLS_MAX = 3'd3;

	localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
	localparam logic [ERR_W-1:0] ERR_CLASS = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_UNUSED,
		ST_READY,
		ST_RUNNING,
		ST_BLOCKED,
		ST_TERMINATED
	} proc_status_t;

	typedef struct packed {
		proc_status_t status;
		logic [1:0] cls;
		logic [LVL_W-1:0] level;
	} proc_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic [LVL_W-1:0] lvl;
	} lvl_cmd_t;

	typedef struct packed {
		logic full;
		logic any;
		logic [LVL_W-1:0] lowest;
	} lvl_stat_t;

	function automatic logic [LVL_W-1:0] start_level(input logic [1:0] cls);
		logic [LVL_W-1:0] lv;
		case (cls)
			2'd0: lv = 4'd0;
			2'd1: lv = 4'd3;
			2'd2: lv = 4'd5;
			default: lv = 4'd7;
		endcase
		return lv;
	endfunction

	function automatic logic [LVL_W-1:0] floor_level(input logic [1:0] cls);
		logic [LVL_W-1:0] lv;
		case (cls)
			2'd0: lv = 4'd2;
			2'd1: lv = 4'd5;
			2'd2: lv = 4'd7;
			default: lv = 4'd9;
		endcase
		return lv;
	endfunction

	function automatic logic [LVL_W-1:0] demote(input logic [LVL_W-1:0] lv,
			input logic [1:0] cls);
		return (lv < floor_level(cls)) ? lv + 4'd1 : lv;
	endfunction

	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lv);
		return (lv < LVL_W'(NUM_LEVELS)) ? lv : LVL_W'(NUM_LEVELS - 1);
	endfunction

endpackage

>>> rtl/core/mfs_proc_table.sv
module mfs_proc_table import mfs_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic rd_en,
	input logic [$clog2(NUM_PROCS)-1:0] rd_addr,
	output proc_entry_t rd_data,
	input logic wr_en,
	input logic [$clog2(NUM_PROCS)-1:0] wr_addr,
	input proc_entry_t wr_data
);

	proc_entry_t mem_q [NUM_PROCS];
	logic [NUM_PROCS-1:0] valid_q;
	proc_entry_t rd_data_s1;
	logic rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads as an unused process.
	assign rd_data = rd_valid_s1 ? rd_data_s1 :
		proc_entry_t'{status: ST_UNUSED, cls: 2'd0, level: '0};

endmodule

>>> rtl/core/mfs_level_store.sv
module mfs_level_store import mfs_pkg::*; #(
	parameter int DEPTH = 160
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [ID_W-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [ID_W-1:0] rd_data
);

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

>>> rtl/core/mfs_level_ptrs.sv
`include "multilevel_feedback_scheduler_assert.svh"

module mfs_level_ptrs import mfs_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input logic clk,
	input logic arst_n,
	input lvl_cmd_t cmd,
	output lvl_stat_t stat,
	output logic [$clog2(NUM_PROCS)-1:0] slot
);

	localparam int PW = $clog2(NUM_PROCS);
	localparam int CW = $clog2(NUM_PROCS + 1);

	logic [PW-1:0] head_q [NUM_LEVELS];
	logic [PW-1:0] tail_q [NUM_LEVELS];
	logic [CW-1:0] count_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] nonempty;
	logic [CW-1:0] sel_count;
	logic [LVL_W-1:0] lowest;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
		return (s == PW'(NUM_PROCS - 1)) ? '0 : s + 1'b1;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			nonempty[i] = count_q[i] != '0;
		end
	end

	always_comb begin
		lowest = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				lowest = LVL_W'(i);
			end
		end
	end

	assign sel_count = count_q[cmd.lvl];
	assign slot = cmd.pop ? head_q[cmd.lvl] : tail_q[cmd.lvl];
	assign stat.full = sel_count == CW'(NUM_PROCS);
	assign stat.any = |nonempty;
	assign stat.lowest = lowest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else if (cmd.push && !stat.full) begin
			tail_q[cmd.lvl] <= next_slot(tail_q[cmd.lvl]);
			count_q[cmd.lvl] <= sel_count + 1'b1;
		end else if (cmd.pop && sel_count != '0) begin
			head_q[cmd.lvl] <= next_slot(head_q[cmd.lvl]);
			count_q[cmd.lvl] <= sel_count - 1'b1;
		end
	end

	`MFS_ASSERT_NEVER(a_push_pop, clk, arst_n, cmd.push && cmd.pop)
	`MFS_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, cmd.pop, sel_count != '0)
	`MFS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, sel_count <= CW'(NUM_PROCS))

endmodule

>>> rtl/core/multilevel_feedback_scheduler.sv
// Ten-level feedback-queue scheduler.
// Input channel: in_valid/in_stall with cmd, proc_id, priority_class,
// running_proc and running_valid. An item is taken when in_valid is high
// and in_stall is low. Output channel: out_valid/out_stall with next_proc,
// next_valid, stop_running and error_code, one result per input item.
// Events other than a dispatching tick read the process table on
// acceptance, update it in S_EXEC and register the result from S_DONE.
// A tick that dispatches goes on from S_EXEC through S_POP, S_PSEL and
// S_DISP before S_DONE, since it walks the process table, the level FIFO
// memory and the process table again through their registered read
// ports. One item is in work at a time.
// A finished result sits in the output register while the next item is
// taken; if the receiver still stalls when that next result is ready,
// the block holds it and keeps in_stall high until the output frees.
// Reset clears every level to empty and marks every process unused;
// no clearing pass is needed and an item may be offered right after.
`include "multilevel_feedback_scheduler_assert.svh"

module multilevel_feedback_scheduler import mfs_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [CMD_W-1:0] cmd,
	input logic [ID_W-1:0] proc_id,
	input logic [CLS_W-1:0] priority_class,
	input logic [ID_W-1:0] running_proc,
	input logic running_valid,
	output logic out_valid,
	input logic out_stall,
	output logic [ID_W-1:0] next_proc,
	output logic next_valid,
	output logic stop_running,
	output logic [ERR_W-1:0] error_code
);

	localparam int PW = $clog2(NUM_PROCS);
	localparam int SDEPTH = NUM_LEVELS * NUM_PROCS;
	localparam int SAW = $clog2(SDEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_PSEL,
		S_DISP,
		S_DONE
	} state_t;

	state_t state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0] id_q;
	logic [CLS_W-1:0] cls_q;
	logic [ID_W-1:0] run_q;
	logic runv_q;
	logic [ID_W-1:0] p_q;
	logic [ID_W-1:0] res_next_q;
	logic res_nv_q;
	logic res_stop_q;
	logic [ERR_W-1:0] res_err_q;
	logic out_valid_q;
	logic [ID_W-1:0] next_proc_q;
	logic next_valid_q;
	logic stop_running_q;
	logic [ERR_W-1:0] error_code_q;

	logic id_ok;
	logic run_ok;
	logic running;
	logic go_pop;
	logic [ID_W-1:0] res_next;
	logic res_nv;
	logic res_stop;
	logic [ERR_W-1:0] res_err;

	logic pt_rd_en;
	logic [PW-1:0] pt_rd_addr;
	proc_entry_t pt_rd_data;
	logic pt_wr_en;
	logic [PW-1:0] pt_wr_addr;
	proc_entry_t pt_wr_data;
	proc_entry_t pe;

	lvl_cmd_t lcmd;
	lvl_stat_t lstat;
	logic [PW-1:0] slot;
	logic push_req;
	logic [LVL_W-1:0] push_lvl;
	logic st_wr_en;
	logic st_rd_en;
	logic [SAW-1:0] st_addr;
	logic [ID_W-1:0] st_wr_data;
	logic [ID_W-1:0] st_rd_data;

	assign in_stall = state_q != S_IDLE;
	assign id_ok = 32'(id_q) < 32'(NUM_PROCS);
	assign run_ok = runv_q && (32'(run_q) < 32'(NUM_PROCS));
	assign pe = pt_rd_data;
	assign running = run_ok && pe.status == ST_RUNNING;

	assign lcmd.push = push_req;
	assign lcmd.pop = state_q == S_POP;
	assign lcmd.lvl = (state_q == S_POP) ? lstat.lowest : push_lvl;
	assign st_addr = SAW'(lcmd.lvl) * SAW'(NUM_PROCS) + SAW'(slot);
	assign st_rd_en = state_q == S_POP;

	always_comb begin
		pt_rd_en = 1'b0;
		pt_rd_addr = PW'(running_proc);
		pt_wr_en = 1'b0;
		pt_wr_addr = PW'(id_q);
		pt_wr_data = pe;
		push_req = 1'b0;
		push_lvl = '0;
		st_wr_en = 1'b0;
		st_wr_data = id_q;
		go_pop = 1'b0;
		res_next = run_q;
		res_nv = runv_q;
		res_stop = 1'b0;
		res_err = ERR_OK;
		case (state_q)
			S_IDLE: begin
				pt_rd_en = in_valid;
				if (cmd == CMD_TICK || cmd == CMD_IOREQ) begin
					pt_rd_addr = PW'(running_proc);
				end else begin
					pt_rd_addr = PW'(proc_id);
				end
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_NEW: begin
						if (id_ok) begin
							if (cls_q > CLS_MAX) begin
								res_err = ERR_CLASS;
							end else begin
								push_req = 1'b1;
								push_lvl = start_level(cls_q[1:0]);
								if (lstat.full) begin
									res_err = ERR_FULL;
								end else begin
									st_wr_en = 1'b1;
									pt_wr_en = 1'b1;
									pt_wr_data.status = ST_READY;
									pt_wr_data.cls = cls_q[1:0];
									pt_wr_data.level = start_level(cls_q[1:0]);
								end
							end
						end
					end
					CMD_IOREQ: begin
						if (run_ok) begin
							pt_wr_en = 1'b1;
							pt_wr_addr = PW'(run_q);
							pt_wr_data.status = ST_BLOCKED;
						end
					end
					CMD_IODONE: begin
						if (id_ok) begin
							push_req = 1'b1;
							push_lvl = start_level(pe.cls);
							if (lstat.full) begin
								res_err = ERR_FULL;
							end else begin
								st_wr_en = 1'b1;
								pt_wr_en = 1'b1;
								pt_wr_data.status = ST_READY;
								pt_wr_data.level = start_level(pe.cls);
							end
						end
					end
					CMD_TERM: begin
						if (id_ok) begin
							pt_wr_en = 1'b1;
							pt_wr_data.status = ST_TERMINATED;
						end
					end
					CMD_TICK: begin
						pt_wr_addr = PW'(run_q);
						st_wr_data = run_q;
						if (lstat.any) begin
							go_pop = 1'b1;
							if (running) begin
								pt_wr_en = 1'b1;
								pt_wr_data.status = ST_READY;
								res_stop = 1'b1;
								push_req = 1'b1;
								push_lvl = clamp_level(pe.level);
								if (lstat.full) begin
									res_err = ERR_FULL;
								end else begin
									st_wr_en = 1'b1;
								end
							end
						end else if (running) begin
							pt_wr_en = 1'b1;
							pt_wr_data.level = demote(pe.level, pe.cls);
							res_nv = 1'b1;
						end else begin
							res_next = '0;
							res_nv = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			S_PSEL: begin
				pt_rd_en = 1'b1;
				pt_rd_addr = PW'(st_rd_data);
			end
			S_DISP: begin
				pt_wr_en = 1'b1;
				pt_wr_addr = PW'(p_q);
				pt_wr_data.status = ST_RUNNING;
				pt_wr_data.level = demote(pe.level, pe.cls);
			end
			default: begin
			end
		endcase
	end

	mfs_proc_table #(
		.NUM_PROCS(NUM_PROCS)
	) u_proc_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(pt_rd_en),
		.rd_addr(pt_rd_addr),
		.rd_data(pt_rd_data),
		.wr_en(pt_wr_en),
		.wr_addr(pt_wr_addr),
		.wr_data(pt_wr_data)
	);

	mfs_level_ptrs #(
		.NUM_PROCS(NUM_PROCS)
	) u_level_ptrs (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(lcmd),
		.stat(lstat),
		.slot(slot)
	);

	mfs_level_store #(
		.DEPTH(SDEPTH)
	) u_level_store (
		.clk(clk),
		.wr_en(st_wr_en),
		.wr_addr(st_addr),
		.wr_data(st_wr_data),
		.rd_en(st_rd_en),
		.rd_addr(st_addr),
		.rd_data(st_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			id_q <= '0;
			cls_q <= '0;
			run_q <= '0;
			runv_q <= 1'b0;
			p_q <= '0;
			res_next_q <= '0;
			res_nv_q <= 1'b0;
			res_stop_q <= 1'b0;
			res_err_q <= ERR_OK;
			out_valid_q <= 1'b0;
			next_proc_q <= '0;
			next_valid_q <= 1'b0;
			stop_running_q <= 1'b0;
			error_code_q <= ERR_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd;
						id_q <= proc_id;
						cls_q <= priority_class;
						run_q <= running_proc;
						runv_q <= running_valid;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_next_q <= res_next;
					res_nv_q <= res_nv;
					res_stop_q <= res_stop;
					res_err_q <= res_err;
					state_q <= go_pop ? S_POP : S_DONE;
				end
				S_POP: begin
					state_q <= S_PSEL;
				end
				S_PSEL: begin
					p_q <= st_rd_data;
					state_q <= S_DISP;
				end
				S_DISP: begin
					res_next_q <= p_q;
					res_nv_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						next_proc_q <= res_next_q;
						next_valid_q <= res_nv_q;
						stop_running_q <= res_stop_q;
						error_code_q <= res_err_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign next_proc = next_proc_q;
	assign next_valid = next_valid_q;
	assign stop_running = stop_running_q;
	assign error_code = error_code_q;

	`MFS_ASSERT_NEVER(a_pt_rw_overlap, clk, arst_n, pt_rd_en && pt_wr_en)
	`MFS_ASSERT_IMPL(a_st_wr_room, clk, arst_n, st_wr_en, lcmd.push && !lstat.full)
	`MFS_ASSERT_IMPL(a_pop_has_item, clk, arst_n, state_q == S_POP, lstat.any)
	`MFS_ASSERT_IMPL(a_stop_dispatch, clk, arst_n, out_valid && stop_running, next_valid)

endmodule

>>> verif/multilevel_feedback_scheduler_tb.sv
module multilevel_feedback_scheduler_tb import mfs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROCS = 16;
	localparam int LEVELS = NUM_LEVELS;
	localparam logic [CLS_W-1:0] CLS_TOP = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNDEF_LAST = 3'd7;

	typedef struct packed {
		logic [ID_W-1:0] proc;
		logic valid;
		logic stop;
		logic [ERR_W-1:0] err;
	} dispatch_t;

	class dispatch_predictor;
		proc_status_t status [PROCS];
		logic [1:0] pclass [PROCS];
		logic [LVL_W-1:0] level [PROCS];
		logic [ID_W-1:0] fifo [LEVELS][PROCS];
		int lvl_head [LEVELS];
		int lvl_tail [LEVELS];
		int lvl_count [LEVELS];
		bit created [PROCS];
		logic [ID_W-1:0] last_proc;
		logic last_valid;
		dispatch_t expected_dispatch_q [$];
		int mismatches;
		int matched;
		int n_items;
		int n_dispatch;
		int n_preempt;
		int n_idle;
		int n_full;
		int n_class_err;

		function new();
			for (int i = 0; i < PROCS; i++) begin
				status[i] = ST_UNUSED;
				created[i] = 1'b0;
			end
			for (int i = 0; i < LEVELS; i++) begin
				lvl_head[i] = 0;
				lvl_tail[i] = 0;
				lvl_count[i] = 0;
			end
			last_proc = '0;
			last_valid = 1'b0;
		endfunction

		function logic [LVL_W-1:0] entry_level(logic [1:0] c);
			case (c)
				2'd0: return 4'd0;
				2'd1: return 4'd3;
				2'd2: return 4'd5;
				default: return 4'd7;
			endcase
		endfunction

		function logic [LVL_W-1:0] bottom_level(logic [1:0] c);
			case (c)
				2'd0: return 4'd2;
				2'd1: return 4'd5;
				2'd2: return 4'd7;
				default: return 4'd9;
			endcase
		endfunction

		function bit enqueue(int lv, logic [ID_W-1:0] p);
			if (lvl_count[lv] >= PROCS)
				return 1'b0;
			fifo[lv][lvl_tail[lv]] = p;
			lvl_tail[lv] = (lvl_tail[lv] + 1) % PROCS;
			lvl_count[lv]++;
			return 1'b1;
		endfunction

		function logic [ID_W-1:0] dequeue(int lv);
			logic [ID_W-1:0] p;
			p = fifo[lv][lvl_head[lv]];
			lvl_head[lv] = (lvl_head[lv] + 1) % PROCS;
			lvl_count[lv]--;
			return p;
		endfunction

		function int first_busy_level();
			for (int i = 0; i < LEVELS; i++)
				if (lvl_count[i] != 0)
					return i;
			return -1;
		endfunction

		function void sink_one(logic [ID_W-1:0] p);
			if (level[p] < bottom_level(pclass[p]))
				level[p] = level[p] + 4'd1;
		endfunction

		function int pending();
			return expected_dispatch_q.size();
		endfunction

		function void note_event(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
				logic [CLS_W-1:0] pc, logic [ID_W-1:0] run, logic rv);
			dispatch_t r;
			bit running;
			int lv;
			logic [ID_W-1:0] p;
			logic [1:0] k;
			r.proc = run;
			r.valid = rv;
			r.stop = 1'b0;
			r.err = ERR_OK;
			n_items++;
			case (c)
				CMD_NEW: begin
					if (pc > CLS_MAX) begin
						r.err = ERR_CLASS;
						n_class_err++;
					end else if (!enqueue(entry_level(pc[1:0]), id)) begin
						r.err = ERR_FULL;
						n_full++;
					end else begin
						pclass[id] = pc[1:0];
						level[id] = entry_level(pc[1:0]);
						status[id] = ST_READY;
						created[id] = 1'b1;
					end
				end
				CMD_IOREQ: begin
					if (rv)
						status[run] = ST_BLOCKED;
				end
				CMD_IODONE: begin
					k = pclass[id];
					if (!enqueue(entry_level(k), id)) begin
						r.err = ERR_FULL;
						n_full++;
					end else begin
						level[id] = entry_level(k);
						status[id] = ST_READY;
					end
				end
				CMD_TERM: begin
					status[id] = ST_TERMINATED;
				end
				CMD_TICK: begin
					running = rv && status[run] == ST_RUNNING;
					lv = first_busy_level();
					if (lv >= 0) begin
						if (running) begin
							status[run] = ST_READY;
							r.stop = 1'b1;
							n_preempt++;
							if (!enqueue(level[run], run)) begin
								r.err = ERR_FULL;
								n_full++;
							end
						end
						lv = first_busy_level();
						p = dequeue(lv);
						status[p] = ST_RUNNING;
						sink_one(p);
						r.proc = p;
						r.valid = 1'b1;
						n_dispatch++;
					end else if (running) begin
						sink_one(run);
						r.proc = run;
						r.valid = 1'b1;
					end else begin
						r.proc = '0;
						r.valid = 1'b0;
						n_idle++;
					end
				end
				default: ;
			endcase
			last_proc = r.proc;
			last_valid = r.valid;
			expected_dispatch_q.push_back(r);
		endfunction

		function void check_dispatch(dispatch_t got);
			dispatch_t want;
			if (expected_dispatch_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: proc %0d valid %0b stop %0b err %0d",
						got.proc, got.valid, got.stop, got.err);
				return;
			end
			want = expected_dispatch_q.pop_front();
			if (got.proc !== want.proc || got.valid !== want.valid
					|| got.stop !== want.stop || got.err !== want.err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected %0d/%0b/%0b/%0d got %0d/%0b/%0b/%0d",
						$time, want.proc, want.valid, want.stop, want.err,
						got.proc, got.valid, got.stop, got.err);
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] cmd;
	logic [ID_W-1:0] proc_id;
	logic [CLS_W-1:0] priority_class;
	logic [ID_W-1:0] running_proc;
	logic running_valid;
	logic out_valid;
	logic out_stall;
	logic [ID_W-1:0] next_proc;
	logic next_valid;
	logic stop_running;
	logic [ERR_W-1:0] error_code;

	dispatch_predictor sched = new();
	int rx_mode;
	int tx_mode;
	int hold_req;
	int hold_done;

	multilevel_feedback_scheduler dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("run timed out with %0d results outstanding", sched.pending());
		$display("multilevel_feedback_scheduler_tb: errors");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sched.check_dispatch({next_proc, next_valid, stop_running, error_code});

	initial begin
		int pick;
		out_stall = 1'b0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req != hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done++;
			end else if (rx_mode == 0) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 12) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else if (pick < 19) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	task automatic offer(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
			input logic [CLS_W-1:0] pc, input logic [ID_W-1:0] rp, input logic rv);
		cmd <= c;
		proc_id <= id;
		priority_class <= pc;
		running_proc <= rp;
		running_valid <= rv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sched.note_event(c, id, pc, rp, rv);
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic sender_gap();
		int pick;
		if (tx_mode == 0)
			return;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			return;
		else if (pick < 18)
			pause_sender($urandom_range(1, 3));
		else
			pause_sender($urandom_range(10, 30));
	endtask

	task automatic drain(input int limit);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (sched.pending() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic random_item();
		logic [CMD_W-1:0] c;
		logic [ID_W-1:0] id;
		logic [CLS_W-1:0] pc;
		logic [ID_W-1:0] rp;
		logic rv;
		int pick;
		int start;
		bit found;
		id = ID_W'($urandom_range(0, PROCS - 1));
		pc = CLS_W'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 8) begin
			rp = sched.last_proc;
			rv = sched.last_valid;
		end else begin
			rp = ID_W'($urandom);
			rv = 1'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 22)
			c = CMD_NEW;
		else if (pick < 57)
			c = CMD_TICK;
		else if (pick < 70)
			c = CMD_IOREQ;
		else if (pick < 85)
			c = CMD_IODONE;
		else if (pick < 93)
			c = CMD_TERM;
		else if (pick < 96) begin
			c = CMD_NEW;
			pc = CLS_MAX + 3'd1 + CLS_W'($urandom_range(0, 3));
		end else
			c = CMD_UNDEF_FIRST + CMD_W'($urandom_range(0, 2));
		if (c == CMD_TERM && rv && $urandom_range(0, 1) == 1)
			id = rp;
		// Completed I/O is mostly for a blocked process; it must name one created before.
		if (c == CMD_IODONE) begin
			found = 1'b0;
			start = $urandom_range(0, PROCS - 1);
			for (int i = 0; i < PROCS && !found; i++)
				if (sched.status[(start + i) % PROCS] == ST_BLOCKED
						&& sched.created[(start + i) % PROCS]) begin
					id = ID_W'((start + i) % PROCS);
					found = 1'b1;
				end
			for (int i = 0; i < PROCS && !found; i++)
				if (sched.created[(start + i) % PROCS]) begin
					id = ID_W'((start + i) % PROCS);
					found = 1'b1;
				end
			if (!found)
				c = CMD_NEW;
		end
		offer(c, id, pc, rp, rv);
		sender_gap();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_NEW;
		proc_id = '0;
		priority_class = CLS_TOP;
		running_proc = '0;
		running_valid = 1'b0;
		rx_mode = 1;
		tx_mode = 0;
		hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ticks with every level empty, then fill the top level past its depth.
		offer(CMD_TICK, 4'd0, CLS_TOP, 4'd0, 1'b0);
		offer(CMD_TICK, 4'd0, CLS_TOP, 4'd5, 1'b1);
		for (int i = 0; i < PROCS; i++)
			offer(CMD_NEW, ID_W'(i), CLS_TOP, 4'd0, 1'b0);
		offer(CMD_NEW, 4'd3, CLS_TOP, 4'd0, 1'b0);
		offer(CMD_NEW, 4'd9, CLS_MAX + 3'd4, 4'd0, 1'b0);
		offer(CMD_UNDEF_LAST, 4'd15, CLS_MAX, 4'd15, 1'b1);
		offer(CMD_TICK, 4'd0, CLS_TOP, 4'd0, 1'b0);
		offer(CMD_TICK, 4'd0, CLS_TOP, sched.last_proc, sched.last_valid);
		offer(CMD_IOREQ, 4'd0, CLS_TOP, sched.last_proc, 1'b1);
		offer(CMD_IODONE, 4'd1, CLS_TOP, 4'd0, 1'b0);
		offer(CMD_TERM, 4'd2, CLS_TOP, 4'd0, 1'b0);
		offer(CMD_IOREQ, 4'd0, CLS_TOP, 4'd15, 1'b0);
		offer(CMD_NEW, 4'd15, CLS_MAX, 4'd0, 1'b0);
		drain(20000);

		rx_mode = 1;
		tx_mode = 1;
		repeat (150) random_item();

		rx_mode = 0;
		tx_mode = 0;
		repeat (100) random_item();

		// The receiver holds off while items keep coming, so the input backs up.
		rx_mode = 1;
		hold_req++;
		repeat (60) random_item();
		drain(20000);

		tx_mode = 1;
		repeat (120) random_item();

		drain(20000);
		repeat (20) @(posedge clk);
		if (sched.pending() != 0) begin
			$display("%0d expected results never arrived", sched.pending());
			sched.mismatches += sched.pending();
		end
		$display("%0d events sent: %0d dispatches, %0d preemptions, %0d idle ticks",
			sched.n_items, sched.n_dispatch, sched.n_preempt, sched.n_idle);
		$display("%0d bad-class and %0d queue-full answers; %0d results matched, %0d mismatched",
			sched.n_class_err, sched.n_full, sched.matched, sched.mismatches);
		if (sched.mismatches == 0)
			$display("multilevel_feedback_scheduler_tb: clean");
		else
			$display("multilevel_feedback_scheduler_tb: errors");
		$finish;
	end

endmodule
